// ===== src/gpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gpsp_pkg
// Shared types, constants and the command frame table of the gamepad serial
// poll engine.
// ----------------------------------------------------------------------------
package gpsp_pkg;

   // Frame geometry
   localparam int FRAME_BYTES = 9;
   localparam int TABLE_BYTES = 9;
   localparam int BYTE_IDX_W  = 4;
   localparam int BIT_IDX_W   = 3;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANALOG_MODE = 2'd2;

   // Reset values of the configuration registers
   localparam logic [7:0]  HALF_PERIOD_RESET = 8'd1;
   localparam logic [15:0] GAP_RESET         = 16'd16;
   localparam logic [7:0]  ANALOG_MODE_RESET = 8'd115;

   // Poll reply header and stick idle value
   localparam logic [7:0]  HDR_IDLE_BYTE = 8'hFF;
   localparam logic [7:0]  HDR_ID_BYTE   = 8'h5A;
   localparam logic [31:0] STICK_CENTRE  = 32'h8080_8080;

   // Requested frame kinds
   typedef enum logic [2:0] {
      FUNC_NONE         = 3'd0,
      FUNC_POLL         = 3'd1,
      FUNC_CONFIG_ENTER = 3'd2,
      FUNC_ANALOG_SET   = 3'd3,
      FUNC_CONFIG_EXIT  = 3'd4
   } func_type;

   // Line sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_SEL_GAP  = 3'd1,
      PH_CLK_LOW  = 3'd2,
      PH_CLK_HIGH = 3'd3,
      PH_BYTE_GAP = 3'd4,
      PH_END_GAP  = 3'd5
   } phase_type;

   // Command bytes of the four frames, in transmit order
   localparam logic [7:0] FRAME_TABLE [4][TABLE_BYTES] = '{
      '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}
   };

   // Command byte for a frame kind and byte position; zero past the table.
   function automatic logic [7:0] frame_byte(input func_type kind,
                                             input logic [BYTE_IDX_W-1:0] idx);
      logic [2:0] row;
      logic [7:0] result;
      row    = 3'(kind) - 3'd1;
      result = 8'h00;
      if (kind == FUNC_POLL || kind == FUNC_CONFIG_ENTER ||
          kind == FUNC_ANALOG_SET || kind == FUNC_CONFIG_EXIT) begin
         if (idx < BYTE_IDX_W'(TABLE_BYTES)) begin
            result = FRAME_TABLE[row[1:0]][idx];
         end
      end
      return result;
   endfunction

endpackage

// ===== src/gamepad_serial_poll_engine.sv =====
// ----------------------------------------------------------------------------
// gamepad_serial_poll_engine
// Tick-driven serial master that clocks fixed command frames to a gamepad and
// decodes its poll replies.
// ----------------------------------------------------------------------------
// Every request transaction is one tick of the line time base, carrying the
// sampled data pin and, while the engine is idle, an optional frame request.
// Each accepted tick yields exactly one response transaction with the line
// levels, status and decoded pad state after that tick. The tick is processed
// combinationally between the sequencer state registers and the response
// register, so one tick is taken every clock while the response side keeps
// up; a stalled response holds back the next tick only while the response
// register is full and not being taken. There is no clearing pass after
// reset. Frame timing is counted in ticks: a frame lasts the request tick,
// 2 gaps and, per byte, 2 * 8 * half_period_ticks ticks plus one further gap,
// where a register value of zero counts as one tick.
// ----------------------------------------------------------------------------
module gamepad_serial_poll_engine (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration writes
   input  logic                          csr_wr_en,
   input  logic [gpsp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gpsp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // Tick requests
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_func,
   input  logic                          req_dat,
   // Tick responses
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_cs_level,
   output logic                          rsp_clk_level,
   output logic                          rsp_cmd_level,
   output logic                          rsp_busy_res,
   output logic                          rsp_frame_done,
   output logic                          rsp_connected,
   output logic [7:0]                    rsp_mode,
   output logic [15:0]                   rsp_buttons,
   output logic [15:0]                   rsp_new_press,
   output logic [31:0]                   rsp_sticks
);
   import gpsp_pkg::*;

   // True once a counted period of len ticks has run out (zero acts as one).
   function automatic logic period_over(input logic [15:0] tick,
                                        input logic [15:0] len);
      return ({1'b0, tick} + 17'd1) >= {1'b0, len};
   endfunction

   // Configuration registers
   logic [7:0]  half_period_ff;
   logic [15:0] gap_ff;
   logic [7:0]  analog_mode_ff;

   // Sequencer state
   phase_type               phase_ff,    phase_in;
   logic [15:0]             tick_ff,     tick_in;
   logic [BIT_IDX_W-1:0]    bit_idx_ff,  bit_idx_in;
   logic [BYTE_IDX_W-1:0]   byte_idx_ff, byte_idx_in;
   func_type                kind_ff,     kind_in;
   logic [7:0]              shift_ff,    shift_in;
   logic                    cmd_ff,      cmd_in;

   // Decoded pad state
   logic                    link_ff,     link_in;
   logic [7:0]              mode_ff,     mode_in;
   logic [15:0]             buttons_ff,  buttons_in;
   logic [15:0]             edge_ff,     edge_in;
   logic [31:0]             sticks_ff,   sticks_in;

   // Received bytes of the current frame, only the parsed positions are kept
   logic [7:0]              rx_ff [TABLE_BYTES];
   logic                    rx_we;
   logic [7:0]              rx_wdata;

   // Response register
   logic                    rsp_valid_ff;
   logic                    done_in;

   logic                    accept;
   logic [7:0]              shift_sampled;
   logic [15:0]             half_len;
   logic [15:0]             buttons_now;
   logic                    header_ok;
   logic [7:0]              cur_byte;
   logic [7:0]              next_byte;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign half_len  = {8'd0, half_period_ff};

   // Configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         gap_ff         <= GAP_RESET;
         analog_mode_ff <= ANALOG_MODE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata[7:0];
            CSR_GAP:         gap_ff         <= csr_wdata;
            CSR_ANALOG_MODE: analog_mode_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Poll reply decode from the stored bytes.
   assign header_ok   = (rx_ff[0] == HDR_IDLE_BYTE) && (rx_ff[1] != HDR_IDLE_BYTE) &&
                        (rx_ff[2] == HDR_ID_BYTE);
   assign buttons_now = ~{rx_ff[4], rx_ff[3]};

   // The data pin folded into the byte being received
   assign shift_sampled = req_dat ? (shift_ff | (8'd1 << bit_idx_ff)) : shift_ff;

   // Command bytes of the current and the following byte position
   assign cur_byte  = frame_byte(kind_ff, byte_idx_ff);
   assign next_byte = frame_byte(kind_ff, byte_idx_ff + 4'd1);

   // Next state of the sequencer for one tick.
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_idx_in  = bit_idx_ff;
      byte_idx_in = byte_idx_ff;
      kind_in     = kind_ff;
      shift_in    = shift_ff;
      cmd_in      = cmd_ff;
      link_in     = link_ff;
      mode_in     = mode_ff;
      buttons_in  = buttons_ff;
      edge_in     = edge_ff;
      sticks_in   = sticks_ff;
      rx_we       = 1'b0;
      rx_wdata    = shift_sampled;
      done_in     = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_func inside {[FUNC_POLL:FUNC_CONFIG_EXIT]}) begin
                  kind_in     = func_type'(req_func);
                  byte_idx_in = '0;
                  bit_idx_in  = '0;
                  shift_in    = '0;
                  tick_in     = '0;
                  phase_in    = PH_SEL_GAP;
               end
            end
            PH_SEL_GAP: begin
               if (period_over(tick_ff, gap_ff)) begin
                  // The byte index is already zero while select settles.
                  byte_idx_in = '0;
                  bit_idx_in  = '0;
                  shift_in    = '0;
                  cmd_in      = cur_byte[0];
                  phase_in    = PH_CLK_LOW;
                  tick_in     = '0;
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
            PH_CLK_LOW: begin
               if (period_over(tick_ff, half_len)) begin
                  phase_in = PH_CLK_HIGH;
                  tick_in  = '0;
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
            PH_CLK_HIGH: begin
               if (period_over(tick_ff, half_len)) begin
                  shift_in = shift_sampled;
                  tick_in  = '0;
                  if (bit_idx_ff != '1) begin
                     bit_idx_in = bit_idx_ff + 1'b1;
                     cmd_in     = cur_byte[bit_idx_ff + 3'd1];
                     phase_in   = PH_CLK_LOW;
                  end else begin
                     rx_we    = 1'b1;
                     phase_in = PH_BYTE_GAP;
                  end
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
            PH_BYTE_GAP: begin
               if (period_over(tick_ff, gap_ff)) begin
                  tick_in = '0;
                  if (({1'b0, byte_idx_ff} + 5'd1) < 5'(FRAME_BYTES)) begin
                     byte_idx_in = byte_idx_ff + 1'b1;
                     bit_idx_in  = '0;
                     shift_in    = '0;
                     cmd_in      = next_byte[0];
                     phase_in    = PH_CLK_LOW;
                  end else begin
                     phase_in = PH_END_GAP;
                  end
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
            PH_END_GAP: begin
               if (period_over(tick_ff, gap_ff)) begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  done_in  = 1'b1;
                  if (kind_ff == FUNC_POLL) begin
                     link_in = header_ok;
                     if (header_ok) begin
                        mode_in    = rx_ff[1];
                        buttons_in = buttons_now;
                        edge_in    = buttons_now & ~buttons_ff;
                        sticks_in  = (rx_ff[1] == analog_mode_ff) ?
                                     {rx_ff[8], rx_ff[7], rx_ff[6], rx_ff[5]} :
                                     STICK_CENTRE;
                     end
                  end
               end else begin
                  tick_in = tick_ff + 16'd1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         endcase
      end
   end

   // Sequencer and pad state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tick_ff     <= '0;
         bit_idx_ff  <= '0;
         byte_idx_ff <= '0;
         kind_ff     <= FUNC_NONE;
         shift_ff    <= '0;
         cmd_ff      <= 1'b1;
         link_ff     <= 1'b0;
         mode_ff     <= '0;
         buttons_ff  <= '0;
         edge_ff     <= '0;
         sticks_ff   <= STICK_CENTRE;
      end else begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_idx_ff  <= bit_idx_in;
         byte_idx_ff <= byte_idx_in;
         kind_ff     <= kind_in;
         shift_ff    <= shift_in;
         cmd_ff      <= cmd_in;
         link_ff     <= link_in;
         mode_ff     <= mode_in;
         buttons_ff  <= buttons_in;
         edge_ff     <= edge_in;
         sticks_ff   <= sticks_in;
      end
   end

   // Received byte store; positions past the parsed header and data are dropped.
   always_ff @(posedge clock) begin
      if (rx_we && (byte_idx_ff < BYTE_IDX_W'(TABLE_BYTES))) begin
         rx_ff[byte_idx_ff] <= rx_wdata;
      end
   end

   // Response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // Response payload, loaded with the state left by each accepted tick
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_cs_level     <= (phase_in == PH_IDLE) || (phase_in == PH_END_GAP);
         rsp_clk_level    <= (phase_in != PH_CLK_LOW);
         rsp_cmd_level    <= cmd_in;
         rsp_busy_res     <= (phase_in != PH_IDLE);
         rsp_frame_done   <= done_in;
         rsp_connected    <= link_in;
         rsp_mode         <= mode_in;
         rsp_buttons      <= buttons_in;
         rsp_new_press    <= edge_in;
         rsp_sticks       <= sticks_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
